// ===== rtl/sapq_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the priority queue
`default_nettype none

package sapq_pkg;

  // queue geometry
  localparam int unsigned DEPTH   = 128;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ENTRY_W = 2 * DATA_W;

  // operation codes
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_TOP,
    S_RESULT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_top;
    logic rd_next;
    logic wr_move;
    logic wr_new;
    logic cap_top;
    logic load_out;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic occ_zero;
    logic occ_full;
    logic ge;
    logic pos_one;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sapq_ram.sv =====
// generic single write port, single read port ram with registered read data
`default_nettype none

module sapq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sapq_ctrl.sv =====
// controller state machine sequencing each queue operation
`default_nettype none

module sapq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_op,
  input  wire sapq_pkg::dp_stat_t stat,
  output logic                    in_stall,
  output sapq_pkg::dp_cmd_t       cmd
);

  sapq_pkg::state_t state_r;
  sapq_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sapq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sapq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (stat.occ_zero) begin
            state_nxt = (in_op == sapq_pkg::OP_ENQUEUE) ? sapq_pkg::S_PLACE
                                                        : sapq_pkg::S_RESULT;
          end else if (in_op == sapq_pkg::OP_ENQUEUE && !stat.occ_full) begin
            state_nxt = sapq_pkg::S_SHIFT;
          end else begin
            state_nxt = sapq_pkg::S_TOP;
          end
        end
      end
      sapq_pkg::S_SHIFT: begin
        if (stat.ge) begin
          state_nxt = stat.pos_one ? sapq_pkg::S_PLACE : sapq_pkg::S_SHIFT;
        end else begin
          state_nxt = sapq_pkg::S_RESULT;
        end
      end
      sapq_pkg::S_PLACE: state_nxt = sapq_pkg::S_RESULT;
      sapq_pkg::S_TOP:   state_nxt = sapq_pkg::S_RESULT;
      sapq_pkg::S_RESULT: begin
        if (stat.out_free) begin
          state_nxt = sapq_pkg::S_IDLE;
        end
      end
      default: state_nxt = sapq_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      sapq_pkg::S_IDLE: begin
        cmd.accept = in_valid;
        // every op with a non-empty queue starts by reading the top entry
        cmd.rd_top = in_valid && !stat.occ_zero;
      end
      sapq_pkg::S_SHIFT: begin
        if (stat.ge) begin
          cmd.wr_move = 1'b1;
          cmd.rd_next = !stat.pos_one;
        end else begin
          cmd.wr_new = 1'b1;
        end
      end
      sapq_pkg::S_PLACE:  cmd.wr_new   = 1'b1;
      sapq_pkg::S_TOP:    cmd.cap_top  = 1'b1;
      sapq_pkg::S_RESULT: cmd.load_out = stat.out_free;
      default:            cmd          = '0;
    endcase
  end

  assign in_stall = (state_r != sapq_pkg::S_IDLE);

`ifndef SYNTH
  // one ram write per cycle
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_move && cmd.wr_new))
    else $error("move and insert written in the same cycle");

  // compare state always sees freshly read data
  a_shift_has_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sapq_pkg::S_SHIFT) |-> $past(cmd.rd_top || cmd.rd_next))
    else $error("shift step without a preceding read");

  // a transaction is latched exactly when the input handshake completes
  a_accept_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept == (in_valid && !in_stall))
    else $error("input accept and latch disagree");
`endif

endmodule

`default_nettype wire

// ===== rtl/sapq_datapath.sv =====
// queue datapath: entry ram, occupancy, insert position and result register
`default_nettype none

module sapq_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire sapq_pkg::dp_cmd_t                      cmd,
  output sapq_pkg::dp_stat_t                          stat,
  input  wire logic [1:0]                             in_op,
  input  wire logic signed [sapq_pkg::DATA_W-1:0]     in_item_value,
  input  wire logic signed [sapq_pkg::DATA_W-1:0]     in_item_priority,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [sapq_pkg::DATA_W-1:0]          out_top_value,
  output logic signed [sapq_pkg::DATA_W-1:0]          out_top_priority,
  output logic [7:0]                                  out_entry_count,
  output logic                                        out_is_empty,
  output logic                                        out_is_full,
  output logic [1:0]                                  out_status
);

  localparam int unsigned AW = sapq_pkg::ADDR_W;
  localparam int unsigned CW = sapq_pkg::CNT_W;
  localparam int unsigned DW = sapq_pkg::DATA_W;
  localparam int unsigned EW = sapq_pkg::ENTRY_W;

  // latched transaction
  logic [1:0]           op_r;
  logic signed [DW-1:0] val_r;
  logic signed [DW-1:0] pri_r;
  logic [1:0]           status_r;
  logic [AW-1:0]        pos_r;
  logic [EW-1:0]        top_r;

  // control registers
  logic [CW-1:0] occ_r;
  logic [CW-1:0] occ_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic signed [DW-1:0] rd_pri;
  logic                 first_step;
  logic                 deq_ok;
  logic                 top_zero;
  logic [1:0]           status_new;

  // entry ram, each word {value, priority}
  sapq_ram #(
    .WIDTH (EW),
    .DEPTH (sapq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ram addressing: writes at the insert position, reads top or the entry below
  assign ram_we    = cmd.wr_move || cmd.wr_new;
  assign ram_waddr = pos_r;
  assign ram_wdata = cmd.wr_move ? ram_rdata : {val_r, pri_r};
  assign ram_re    = cmd.rd_top || cmd.rd_next;
  assign ram_raddr = cmd.rd_top ? AW'(occ_r - CW'(1)) : (pos_r - AW'(2));

  // status toward the controller
  assign rd_pri        = ram_rdata[DW-1:0];
  assign stat.occ_zero = (occ_r == '0);
  assign stat.occ_full = (occ_r == CW'(sapq_pkg::DEPTH));
  assign stat.ge       = (rd_pri >= pri_r);
  assign stat.pos_one  = (pos_r == AW'(1));
  assign stat.out_free = !out_valid_r || !out_stall;

  // first write of an insert decides the new top entry
  assign first_step = (CW'(pos_r) == occ_r);

  // status of an incoming transaction
  always_comb begin
    status_new = sapq_pkg::STAT_OK;
    if (in_op == sapq_pkg::OP_ENQUEUE && stat.occ_full) begin
      status_new = sapq_pkg::STAT_FULL;
    end else if ((in_op == sapq_pkg::OP_DEQUEUE || in_op == sapq_pkg::OP_PEEK) &&
                 stat.occ_zero) begin
      status_new = sapq_pkg::STAT_EMPTY;
    end
  end

  // occupancy after the operation
  assign deq_ok = (op_r == sapq_pkg::OP_DEQUEUE) && (status_r == sapq_pkg::STAT_OK);

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.load_out && status_r == sapq_pkg::STAT_OK) begin
      if (op_r == sapq_pkg::OP_ENQUEUE) begin
        occ_nxt = occ_r + CW'(1);
      end else if (op_r == sapq_pkg::OP_DEQUEUE) begin
        occ_nxt = occ_r - CW'(1);
      end
    end
  end

  // result valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // transaction latch and insert position
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_op;
      val_r    <= in_item_value;
      pri_r    <= in_item_priority;
      status_r <= status_new;
      pos_r    <= AW'(occ_r);
    end else if (cmd.wr_move) begin
      pos_r <= pos_r - AW'(1);
    end
  end

  // top entry capture
  always_ff @(posedge clk) begin
    if (cmd.cap_top) begin
      top_r <= ram_rdata;
    end else if (cmd.wr_move && first_step) begin
      top_r <= ram_rdata;
    end else if (cmd.wr_new && first_step) begin
      top_r <= {val_r, pri_r};
    end
  end

  // result register
  assign top_zero = (occ_nxt == '0) && !deq_ok;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_top_value    <= top_zero ? '0 : top_r[EW-1:DW];
      out_top_priority <= top_zero ? '0 : top_r[DW-1:0];
      out_entry_count  <= 8'(occ_nxt);
      out_is_empty     <= (occ_nxt == '0);
      out_is_full      <= (occ_nxt == CW'(sapq_pkg::DEPTH));
      out_status       <= status_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // occupancy never exceeds the ram depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(sapq_pkg::DEPTH))
    else $error("occupancy above depth");

  // a move never targets the bottom slot
  a_move_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_move |-> (pos_r != '0))
    else $error("shift into slot zero");

  // loading a result always presents it next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// ===== rtl/sorted_array_priority_queue.sv =====
// top level of the sorted array max priority queue
//
// Input channel in_valid/in_stall carries one transaction: in_op (0 enqueue,
// 1 dequeue highest, 2 peek highest), in_item_value and in_item_priority.
// Every accepted transaction gives exactly one result transaction on
// out_valid/out_stall: top entry, entry count, empty/full flags and status.
// Entries sit in one ram sorted by ascending priority; equal priorities
// leave in arrival order.
// On an empty queue dequeue and peek go straight to the result and an
// enqueue writes its entry at once; otherwise dequeue, peek and a rejected
// enqueue read the top entry, and an enqueue moves up each entry whose
// priority is not below its own. The insert walk moves one entry per cycle
// through the single write port of the entry ram; the result appears in the
// same cycle as the next transaction can be taken.
// Reset (synchronous, rst_n low) empties the queue and drops any pending
// result; ram contents are not cleared. While out_stall is high and a
// result is pending, the result register holds and the block finishes the
// current transaction, then waits with in_stall high until the result is taken.
`default_nettype none

module sorted_array_priority_queue (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_op,
  input  wire logic signed [sapq_pkg::DATA_W-1:0] in_item_value,
  input  wire logic signed [sapq_pkg::DATA_W-1:0] in_item_priority,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [sapq_pkg::DATA_W-1:0]      out_top_value,
  output logic signed [sapq_pkg::DATA_W-1:0]      out_top_priority,
  output logic [7:0]                              out_entry_count,
  output logic                                    out_is_empty,
  output logic                                    out_is_full,
  output logic [1:0]                              out_status
);

  sapq_pkg::dp_cmd_t  cmd;
  sapq_pkg::dp_stat_t stat;

  // operation sequencer
  sapq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // storage and result path
  sapq_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_op),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_top_value    (out_top_value),
    .out_top_priority (out_top_priority),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

// ===== test/sapq_checker.sv =====
// result predictor and scoreboard for the sorted array priority queue
`default_nettype none

module sapq_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic [1:0]                          in_op,
  input  wire logic signed [sapq_pkg::DATA_W-1:0]  in_item_value,
  input  wire logic signed [sapq_pkg::DATA_W-1:0]  in_item_priority,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic signed [sapq_pkg::DATA_W-1:0]  out_top_value,
  input  wire logic signed [sapq_pkg::DATA_W-1:0]  out_top_priority,
  input  wire logic [7:0]                          out_entry_count,
  input  wire logic                                out_is_empty,
  input  wire logic                                out_is_full,
  input  wire logic [1:0]                          out_status,
  output int                                       fail_count,
  output int                                       pending,
  output int                                       checked,
  output int                                       full_rejects,
  output int                                       empty_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [sapq_pkg::DATA_W-1:0] top_value;
    logic signed [sapq_pkg::DATA_W-1:0] top_priority;
    logic [7:0]                         entry_count;
    logic                               is_empty;
    logic                               is_full;
    logic [1:0]                         status;
  } qresult_t;

  // shadow copy of the queue, ascending priority, top at held_count-1
  logic signed [sapq_pkg::DATA_W-1:0] held_value    [sapq_pkg::DEPTH];
  logic signed [sapq_pkg::DATA_W-1:0] held_priority [sapq_pkg::DEPTH];
  int unsigned                        held_count;

  // results predicted but not yet seen, oldest first
  qresult_t                           awaited_q [$];

  // apply one operation to the shadow queue and work out its result
  task automatic apply_op(input logic [1:0] op,
                          input logic signed [sapq_pkg::DATA_W-1:0] val,
                          input logic signed [sapq_pkg::DATA_W-1:0] pri,
                          output qresult_t res);
    int unsigned pos;
    logic        shown;
    res   = '0;
    shown = 1'b0;
    case (op)
      sapq_pkg::OP_ENQUEUE: begin
        if (held_count >= sapq_pkg::DEPTH) begin
          res.status = sapq_pkg::STAT_FULL;
        end else begin
          // entries with priority >= new one move up, new one goes below them
          pos = held_count;
          while (pos > 0 && held_priority[pos-1] >= pri) begin
            held_value[pos]    = held_value[pos-1];
            held_priority[pos] = held_priority[pos-1];
            pos--;
          end
          held_value[pos]    = val;
          held_priority[pos] = pri;
          held_count++;
        end
      end
      sapq_pkg::OP_DEQUEUE: begin
        if (held_count == 0) begin
          res.status = sapq_pkg::STAT_EMPTY;
        end else begin
          held_count--;
          res.top_value    = held_value[held_count];
          res.top_priority = held_priority[held_count];
          shown            = 1'b1;
        end
      end
      sapq_pkg::OP_PEEK: begin
        if (held_count == 0) res.status = sapq_pkg::STAT_EMPTY;
      end
      default: begin
        // spare code leaves the queue alone
      end
    endcase
    if (!shown && held_count > 0) begin
      res.top_value    = held_value[held_count-1];
      res.top_priority = held_priority[held_count-1];
    end
    res.entry_count = 8'(held_count);
    res.is_empty    = (held_count == 0);
    res.is_full     = (held_count == sapq_pkg::DEPTH);
  endtask

  // field by field comparison, returns the number of wrong fields
  function automatic int compare_result(input qresult_t got, input qresult_t want);
    int errs;
    errs = 0;
    if (got.top_value !== want.top_value) begin
      $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
      errs++;
    end
    if (got.top_priority !== want.top_priority) begin
      $error("top_priority: expected %0d, got %0d", want.top_priority, got.top_priority);
      errs++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      errs++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
      errs++;
    end
    if (got.is_full !== want.is_full) begin
      $error("is_full: expected %0b, got %0b", want.is_full, got.is_full);
      errs++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errs++;
    end
    return errs;
  endfunction

  // watch both channels at each clock edge
  always @(posedge clk) begin : watch
    qresult_t res;
    qresult_t got;
    int       errs;
    if (!rst_n) begin
      held_count = 0;
      awaited_q.delete();
      fail_count   <= 0;
      pending      <= 0;
      checked      <= 0;
      full_rejects <= 0;
      empty_reads  <= 0;
    end else begin
      errs = 0;
      // accepted input transaction
      if (in_valid && !in_stall) begin
        apply_op(in_op, in_item_value, in_item_priority, res);
        awaited_q.push_back(res);
        if (res.status == sapq_pkg::STAT_FULL) full_rejects <= full_rejects + 1;
        if (res.status == sapq_pkg::STAT_EMPTY) empty_reads <= empty_reads + 1;
      end
      // accepted result transaction
      if (out_valid && !out_stall) begin
        got = '{out_top_value, out_top_priority, out_entry_count,
                out_is_empty, out_is_full, out_status};
        if (awaited_q.size() == 0) begin
          $error("result transaction with nothing awaited: value %0d priority %0d",
                 out_top_value, out_top_priority);
          errs++;
        end else begin
          errs += compare_result(got, awaited_q.pop_front());
        end
        checked <= checked + 1;
      end
      fail_count <= fail_count + errs;
      pending    <= awaited_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// stimulus, handshake pressure and verdict for the sorted array priority queue
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam int         LIMIT      = 2_000_000;
  localparam int         TAIL       = sapq_pkg::DEPTH + 16;
  localparam int         PHASE_ITEMS = 485;

  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_CHURN } mix_t;

  logic                               clk;
  logic                               rst_n            = 1'b0;
  logic                               in_valid         = 1'b0;
  logic                               in_stall;
  logic [1:0]                         in_op            = sapq_pkg::OP_PEEK;
  logic signed [sapq_pkg::DATA_W-1:0] in_item_value    = '0;
  logic signed [sapq_pkg::DATA_W-1:0] in_item_priority = '0;
  logic                               out_valid;
  logic                               out_stall        = 1'b0;
  logic signed [sapq_pkg::DATA_W-1:0] out_top_value;
  logic signed [sapq_pkg::DATA_W-1:0] out_top_priority;
  logic [7:0]                         out_entry_count;
  logic                               out_is_empty;
  logic                               out_is_full;
  logic [1:0]                         out_status;

  int fail_count;
  int pending;
  int checked;
  int full_rejects;
  int empty_reads;
  int idle_pct  = 0;
  int stall_pct = 0;
  int n_sent    = 0;
  int cycle_count = 0;
  logic signed [sapq_pkg::DATA_W-1:0] ramp = 32'sd100000;

  sorted_array_priority_queue i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_top_value    (out_top_value),
    .out_top_priority (out_top_priority),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .out_status       (out_status)
  );

  sapq_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_top_value    (out_top_value),
    .out_top_priority (out_top_priority),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked),
    .full_rejects     (full_rejects),
    .empty_reads      (empty_reads)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stall, redrawn every cycle
  initial begin
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL sorted_array_priority_queue");
    $finish;
  end

  // one input transaction, with a random idle gap in front of it
  task automatic push_op(input logic [1:0] op,
                         input logic signed [sapq_pkg::DATA_W-1:0] val,
                         input logic signed [sapq_pkg::DATA_W-1:0] pri);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_item_value    <= val;
    in_item_priority <= pri;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // sender holds off until every awaited result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // extreme and near-extreme words
  function automatic logic signed [sapq_pkg::DATA_W-1:0] corner_word();
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4:       return 32'sd1;
      default: return 32'sh8000_0001;
    endcase
  endfunction

  // priority mix: full range, dense ties, corners, and a falling ramp
  // whose every new entry sits below all earlier ramp entries
  task automatic pick_priority(output logic signed [sapq_pkg::DATA_W-1:0] pri);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      pri = $urandom;
    end else if (roll < 70) begin
      pri = $signed($urandom_range(0, 8)) - 4;
    end else if (roll < 85) begin
      pri = corner_word();
    end else begin
      pri  = ramp;
      ramp = ramp - 1;
    end
  endtask

  // random transactions in chunks that fill, drain or churn the queue
  task automatic run_random(input int n_items);
    mix_t                               mix;
    int                                 left;
    int                                 roll;
    logic [1:0]                         op;
    logic signed [sapq_pkg::DATA_W-1:0] val;
    logic signed [sapq_pkg::DATA_W-1:0] pri;
    mix  = MIX_FILL;
    left = $urandom_range(160, 220);
    for (int i = 0; i < n_items; i++) begin
      if (left == 0) begin
        mix  = mix_t'($urandom_range(0, 2));
        left = $urandom_range(60, 200);
      end
      left--;
      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:  op = roll < 85 ? sapq_pkg::OP_ENQUEUE : roll < 95 ? sapq_pkg::OP_DEQUEUE :
                        roll < 99 ? sapq_pkg::OP_PEEK : OP_SPARE;
        MIX_DRAIN: op = roll < 10 ? sapq_pkg::OP_ENQUEUE : roll < 88 ? sapq_pkg::OP_DEQUEUE :
                        roll < 98 ? sapq_pkg::OP_PEEK : OP_SPARE;
        default:   op = roll < 45 ? sapq_pkg::OP_ENQUEUE : roll < 80 ? sapq_pkg::OP_DEQUEUE :
                        roll < 98 ? sapq_pkg::OP_PEEK : OP_SPARE;
      endcase
      val = ($urandom_range(0, 9) == 0) ? corner_word() : $signed($urandom);
      pick_priority(pri);
      push_op(op, val, pri);
    end
  endtask

  // one pressure phase followed by a full drain
  task automatic run_phase(input int idle, input int stall, input int n_items);
    idle_pct  = idle;
    stall_pct <= stall;
    run_random(n_items);
    wait_drained();
  endtask

  // main sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue reads, corners, ties, lowest-of-all insert
    push_op(sapq_pkg::OP_DEQUEUE, 32'sd0, 32'sd0);
    push_op(sapq_pkg::OP_PEEK, 32'sd0, 32'sd0);
    push_op(OP_SPARE, 32'sd0, 32'sd0);
    push_op(sapq_pkg::OP_ENQUEUE, 32'sh7fff_ffff, 32'sd0);
    push_op(sapq_pkg::OP_ENQUEUE, 32'sh8000_0000, 32'sh8000_0000);
    push_op(sapq_pkg::OP_ENQUEUE, 32'sd0, 32'sh7fff_ffff);
    push_op(sapq_pkg::OP_ENQUEUE, -32'sd1, 32'sd0);
    push_op(sapq_pkg::OP_PEEK, 32'sd0, 32'sd0);
    push_op(OP_SPARE, -32'sd1, -32'sd1);
    push_op(sapq_pkg::OP_ENQUEUE, 32'sh5555_5555, -32'sd1);
    push_op(sapq_pkg::OP_ENQUEUE, 32'shaaaa_aaaa, 32'sh7fff_ffff);
    push_op(sapq_pkg::OP_ENQUEUE, 32'sd7, 32'sh8000_0000);
    push_op(sapq_pkg::OP_DEQUEUE, 32'sd0, 32'sd0);
    push_op(sapq_pkg::OP_DEQUEUE, 32'sd0, 32'sd0);
    push_op(sapq_pkg::OP_PEEK, 32'sd0, 32'sd0);
    push_op(sapq_pkg::OP_DEQUEUE, 32'sd0, 32'sd0);
    push_op(sapq_pkg::OP_DEQUEUE, 32'sd0, 32'sd0);
    push_op(sapq_pkg::OP_DEQUEUE, 32'sd0, 32'sd0);
    push_op(sapq_pkg::OP_DEQUEUE, 32'sd0, 32'sd0);
    push_op(sapq_pkg::OP_DEQUEUE, 32'sd0, 32'sd0);
    push_op(sapq_pkg::OP_DEQUEUE, 32'sd0, 32'sd0);
    push_op(sapq_pkg::OP_PEEK, 32'sd0, 32'sd0);
    wait_drained();

    // random phases: free running, idle sender, stalling receiver, both
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(72, 0, PHASE_ITEMS);
    run_phase(0, 72, PHASE_ITEMS);
    run_phase(32, 32, PHASE_ITEMS);

    // let any stray result show up before the verdict
    stall_pct <= 0;
    repeat (TAIL) @(posedge clk);

    $display("sent %0d transactions through four handshake phases, %0d results checked",
             n_sent, checked);
    $display("full queue rejected %0d enqueues, empty queue answered %0d reads",
             full_rejects, empty_reads);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS sorted_array_priority_queue");
    end else begin
      $display("FAIL sorted_array_priority_queue");
    end
    $finish;
  end

endmodule

`default_nettype wire
